[rtl/sgc_pkg.sv]
// Shared types, constants and saturating Q32.32 helpers for the stiffened-gas converter.
`timescale 1ns / 1ps
package sgc_pkg;

  typedef logic signed [63:0]  q_t;
  typedef logic signed [127:0] qw_t;

  typedef struct packed {
    logic command;
    q_t   density_in;
    q_t   second_in;
    q_t   third_in;
    q_t   fourth_in;
  } sgc_in_t;

  typedef struct packed {
    q_t   density_out;
    q_t   second_out;
    q_t   third_out;
    q_t   fourth_out;
    logic error_flag;
  } sgc_out_t;

  typedef struct packed {
    q_t   val;
    logic err;
  } sres_t;

  localparam logic CMD_P2C = 1'b0;
  localparam logic CMD_C2P = 1'b1;

  localparam logic REG_GAMMA = 1'b0;
  localparam logic REG_PINF  = 1'b1;

  localparam int GAMMA_W = 36;
  localparam int PINF_W  = 63;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 64;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 36'd6012954214;

  localparam q_t Q_ONE = 64'sh0000_0001_0000_0000;
  localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;

  // product >>> 32, saturated
  function automatic sres_t sat_prod(input qw_t w);
    sres_t r;
    if (w[127:95] == '0 || w[127:95] == '1) begin
      r.val = q_t'(w[95:32]);
      r.err = 1'b0;
    end else begin
      r.val = w[127] ? Q_MIN : Q_MAX;
      r.err = 1'b1;
    end
    return r;
  endfunction

  function automatic sres_t sat65(input logic [64:0] s);
    sres_t r;
    if (s[64] != s[63]) begin
      r.val = s[64] ? Q_MIN : Q_MAX;
      r.err = 1'b1;
    end else begin
      r.val = q_t'(s[63:0]);
      r.err = 1'b0;
    end
    return r;
  endfunction

  function automatic sres_t sat_add(input q_t a, input q_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    return sat65(s);
  endfunction

  function automatic sres_t sat_sub(input q_t a, input q_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    return sat65(s);
  endfunction

  function automatic q_t half_q(input q_t x);
    return x >>> 1;
  endfunction

  // a * 2^32 as a wide numerator
  function automatic qw_t q2w(input q_t a);
    return qw_t'({{32{a[63]}}, a, 32'b0});
  endfunction

endpackage

[rtl/sgc_stream_if.sv]
// Valid/ready stream channel carrying one payload struct.
`timescale 1ns / 1ps
interface sgc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/sgc_mul.sv]
// Two-stage signed 64x64 multiplier built from 32-bit partial products.
`timescale 1ns / 1ps
module sgc_mul import sgc_pkg::*; (
  input  logic clk,
  input  logic en,
  input  q_t   a,
  input  q_t   b,
  output qw_t  p
);
  logic [63:0]        pp00_r;
  logic signed [64:0] pp01_r;
  logic signed [64:0] pp10_r;
  logic signed [63:0] pp11_r;
  qw_t                p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= a[31:0] * b[31:0];
      pp01_r <= $signed({1'b0, a[31:0]}) * $signed(b[63:32]);
      pp10_r <= $signed(a[63:32]) * $signed({1'b0, b[31:0]});
      pp11_r <= $signed(a[63:32]) * $signed(b[63:32]);
      p_r    <= qw_t'({64'b0, pp00_r}
                      + {{31{pp01_r[64]}}, pp01_r, 32'b0}
                      + {{31{pp10_r[64]}}, pp10_r, 32'b0}
                      + {pp11_r, 64'b0});
    end
  end

  assign p = p_r;
endmodule

[rtl/sgc_div.sv]
// Pipelined restoring divider: floor(num / den), saturated to 64 bits.
`timescale 1ns / 1ps
module sgc_div import sgc_pkg::*; #(
  parameter int STEP_BITS = 2
) (
  input  logic clk,
  input  logic en,
  input  qw_t  num,
  input  q_t   den,
  output q_t   quo,
  output logic err
);
  localparam int STAGES = 64 / STEP_BITS;

  typedef struct packed {
    logic        negq;
    logic        negn;
    logic        dz;
    logic        nz;
    logic        ovf;
    logic [63:0] ud;
  } dctl_t;

  dctl_t       ctl_r [STAGES+1];
  logic [63:0] rem_r [STAGES+1];
  logic [63:0] qn_r  [STAGES+1];

  logic [127:0] un;
  dctl_t        ctl_nxt;

  always_comb begin
    un              = num[127] ? (~num + 128'd1) : num;
    ctl_nxt.ud      = den[63] ? (~den + 64'd1) : den;
    ctl_nxt.negn    = num[127];
    ctl_nxt.negq    = num[127] != den[63];
    ctl_nxt.dz      = den == '0;
    ctl_nxt.nz      = num == '0;
    ctl_nxt.ovf     = un[127:64] >= ctl_nxt.ud;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl_nxt;
      rem_r[0] <= un[127:64];
      qn_r[0]  <= un[63:0];
    end
  end

  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    logic [63:0] rem_c;
    logic [63:0] qn_c;
    logic [64:0] trial;

    always_comb begin
      rem_c = rem_r[s-1];
      qn_c  = qn_r[s-1];
      trial = '0;
      for (int k = 0; k < STEP_BITS; k++) begin
        trial = {rem_c, qn_c[63]};
        qn_c  = {qn_c[62:0], 1'b0};
        if (trial >= {1'b0, ctl_r[s-1].ud}) begin
          trial   = trial - {1'b0, ctl_r[s-1].ud};
          qn_c[0] = 1'b1;
        end
        rem_c = trial[63:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_c;
        qn_r[s]  <= qn_c;
        ctl_r[s] <= ctl_r[s-1];
      end
    end
  end

  dctl_t       cf;
  logic [64:0] qa;
  q_t          quo_nxt;
  logic        err_nxt;
  q_t          quo_r;
  logic        err_r;

  always_comb begin
    cf      = ctl_r[STAGES];
    qa      = {1'b0, qn_r[STAGES]} + {64'b0, (rem_r[STAGES] != '0)};
    quo_nxt = '0;
    err_nxt = 1'b0;
    if (cf.dz) begin
      err_nxt = 1'b1;
      quo_nxt = cf.nz ? q_t'(0) : (cf.negn ? Q_MIN : Q_MAX);
    end else if (!cf.negq) begin
      if (cf.ovf || qn_r[STAGES][63]) begin
        err_nxt = 1'b1;
        quo_nxt = Q_MAX;
      end else begin
        quo_nxt = q_t'(qn_r[STAGES]);
      end
    end else if (cf.ovf || qa > 65'h0_8000_0000_0000_0000) begin
      err_nxt = 1'b1;
      quo_nxt = Q_MIN;
    end else begin
      quo_nxt = q_t'(~qa[63:0] + 64'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      err_r <= err_nxt;
    end
  end

  assign quo = quo_r;
  assign err = err_r;
endmodule

[rtl/stiffened_gas_state_conversion_top.sv]
// Top level: stiffened-gas primitive/conservative state converter pipeline.
//
//   port group | dir | handshake                | contents
//   in_chan    | in  | valid/ready              | command, density, three state values
//   out_chan   | out | valid/ready              | four converted values, error flag
//   APB        | in  | psel/penable/pwrite      | gamma_ratio @0x0, stiffening_pressure @0x8
//
// One transaction per cycle sustained while not stalled. Pipeline depth is set by
// the pipelined divider (DIV_STEP_BITS quotient bits per stage). rst_n clears the
// valid bits and output valid flag and resets the config registers. A stall holds
// the whole pipeline only when its last stage and the output register are both
// full and out_chan is not ready; bubbles keep moving and inputs keep being taken.
`timescale 1ns / 1ps
module stiffened_gas_state_conversion_top import sgc_pkg::*; #(
  parameter int DIV_STEP_BITS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  sgc_stream_if.sink        in_chan,
  sgc_stream_if.source      out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);
  localparam int DIV_LAT = 64 / DIV_STEP_BITS + 2;
  localparam int NST     = DIV_LAT + 10;

  typedef struct packed {
    logic cmd;
    q_t   rho;
    q_t   a4;
    q_t   o2;
    q_t   o3;
    q_t   gp;
    q_t   sq;
    logic err0;
    logic errgp;
  } side_d_t;

  typedef struct packed {
    side_d_t side;
    q_t      inner;
    q_t      v;
    logic    err;
  } side_h_t;

  // ---------------- configuration ----------------
  logic [GAMMA_W-1:0] gamma_r;
  logic [PINF_W-1:0]  pinf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
      pinf_r  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3])
        REG_GAMMA: gamma_r <= pwdata[GAMMA_W-1:0];
        REG_PINF:  pinf_r  <= pwdata[PINF_W-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_PINF) ? DATA_W'(pinf_r) : DATA_W'(gamma_r);

  q_t g_q, pinf_q, gm1;
  assign g_q    = q_t'({28'b0, gamma_r});
  assign pinf_q = q_t'({1'b0, pinf_r});
  assign gm1    = g_q - Q_ONE;

  // ---------------- control ----------------
  logic [NST-1:0] v_r;
  logic           en;
  logic           out_valid_r;
  logic           out_valid_nxt;
  sgc_out_t       out_r;
  sgc_out_t       fin_r;

  assign en            = !(v_r[NST-1] && out_valid_r && !out_chan.ready);
  assign in_chan.ready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_chan.valid};
    end
  end

  // ---------------- stage A and first multiplies ----------------
  sgc_in_t a_r;
  sgc_in_t m1_side_r [2];
  qw_t     p_ru, p_rv, p_uu, p_vv, p_gp;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r          <= in_chan.payload;
      m1_side_r[0] <= a_r;
      m1_side_r[1] <= m1_side_r[0];
    end
  end

  sgc_mul u_mul_ru (.clk, .en, .a(a_r.density_in), .b(a_r.second_in), .p(p_ru));
  sgc_mul u_mul_rv (.clk, .en, .a(a_r.density_in), .b(a_r.third_in),  .p(p_rv));
  sgc_mul u_mul_uu (.clk, .en, .a(a_r.second_in),  .b(a_r.second_in), .p(p_uu));
  sgc_mul u_mul_vv (.clk, .en, .a(a_r.third_in),   .b(a_r.third_in),  .p(p_vv));
  sgc_mul u_mul_gp (.clk, .en, .a(g_q),            .b(pinf_q),        .p(p_gp));

  // ---------------- stage C ----------------
  sgc_in_t c_in_r;
  q_t      c_o2_r, c_o3_r, c_gp_r, c_k2_r, c_k3_r;
  qw_t     c_uu_r, c_vv_r;
  logic    c_err0_r, c_errgp_r;
  sres_t   s_o2, s_o3, s_gp, s_k2, s_k3;

  always_comb begin
    s_o2 = sat_prod(p_ru);
    s_o3 = sat_prod(p_rv);
    s_gp = sat_prod(p_gp);
    s_k2 = sat_prod(p_uu);
    s_k3 = sat_prod(p_vv);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_in_r    <= m1_side_r[1];
      c_o2_r    <= s_o2.val;
      c_o3_r    <= s_o3.val;
      c_gp_r    <= s_gp.val;
      c_k2_r    <= s_k2.val;
      c_k3_r    <= s_k3.val;
      c_uu_r    <= p_uu;
      c_vv_r    <= p_vv;
      c_err0_r  <= s_o2.err | s_o3.err | s_gp.err | s_k2.err | s_k3.err;
      c_errgp_r <= s_gp.err;
    end
  end

  // ---------------- stage D ----------------
  sgc_in_t d_in_r;
  q_t      d_o2_r, d_o3_r, d_gp_r, d_sq_r, d_num_r;
  qw_t     d_uu_r, d_vv_r;
  logic    d_err0_r, d_errgp_r;
  sres_t   s_sq, s_num;

  always_comb begin
    s_sq  = sat_add(c_k2_r, c_k3_r);
    s_num = sat_add(c_in_r.fourth_in, c_gp_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_in_r    <= c_in_r;
      d_o2_r    <= c_o2_r;
      d_o3_r    <= c_o3_r;
      d_gp_r    <= c_gp_r;
      d_sq_r    <= s_sq.val;
      d_num_r   <= s_num.val;
      d_uu_r    <= c_uu_r;
      d_vv_r    <= c_vv_r;
      d_err0_r  <= c_err0_r | s_sq.err | s_num.err;
      d_errgp_r <= c_errgp_r;
    end
  end

  // ---------------- dividers ----------------
  qw_t     div0_num;
  q_t      div0_den;
  q_t      q0, q1, q2, q3;
  logic    e0, e1, e2, e3;
  side_d_t dv_side_r [DIV_LAT];

  assign div0_num = (d_in_r.command == CMD_P2C) ? q2w(d_num_r) : q2w(d_in_r.second_in);
  assign div0_den = (d_in_r.command == CMD_P2C) ? gm1 : d_in_r.density_in;

  sgc_div #(.STEP_BITS(DIV_STEP_BITS)) u_div0 (
    .clk, .en, .num(div0_num), .den(div0_den), .quo(q0), .err(e0));
  sgc_div #(.STEP_BITS(DIV_STEP_BITS)) u_div1 (
    .clk, .en, .num(q2w(d_in_r.third_in)), .den(d_in_r.density_in), .quo(q1), .err(e1));
  sgc_div #(.STEP_BITS(DIV_STEP_BITS)) u_div2 (
    .clk, .en, .num(d_uu_r), .den(d_in_r.density_in), .quo(q2), .err(e2));
  sgc_div #(.STEP_BITS(DIV_STEP_BITS)) u_div3 (
    .clk, .en, .num(d_vv_r), .den(d_in_r.density_in), .quo(q3), .err(e3));

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0] <= '{cmd: d_in_r.command, rho: d_in_r.density_in, a4: d_in_r.fourth_in,
                        o2: d_o2_r, o3: d_o3_r, gp: d_gp_r, sq: d_sq_r,
                        err0: d_err0_r, errgp: d_errgp_r};
      for (int i = 1; i < DIV_LAT; i++) begin
        dv_side_r[i] <= dv_side_r[i-1];
      end
    end
  end

  // ---------------- stage F ----------------
  side_d_t f_side_r;
  q_t      f_inner_r, f_v_r, f_kin_r;
  logic    f_err_r;
  logic    f_err_nxt;
  sres_t   s_kin;

  always_comb begin
    s_kin = sat_add(half_q(q2), half_q(q3));
    if (dv_side_r[DIV_LAT-1].cmd == CMD_P2C) begin
      f_err_nxt = dv_side_r[DIV_LAT-1].err0 | e0;
    end else begin
      f_err_nxt = dv_side_r[DIV_LAT-1].errgp | e0 | e1 | e2 | e3 | s_kin.err;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_side_r  <= dv_side_r[DIV_LAT-1];
      f_inner_r <= q0;
      f_v_r     <= q1;
      f_kin_r   <= s_kin.val;
      f_err_r   <= f_err_nxt;
    end
  end

  // ---------------- stage G and final multiply ----------------
  side_d_t g_side_r;
  q_t      g_ma_r, g_mb_r, g_inner_r, g_v_r;
  logic    g_err_r;
  sres_t   s_e;
  qw_t     p_fin;
  side_h_t h_side_r [2];

  assign s_e = sat_sub(f_side_r.a4, f_kin_r);

  always_ff @(posedge clk) begin
    if (en) begin
      g_side_r  <= f_side_r;
      g_inner_r <= f_inner_r;
      g_v_r     <= f_v_r;
      if (f_side_r.cmd == CMD_P2C) begin
        g_ma_r  <= f_side_r.rho;
        g_mb_r  <= f_side_r.sq;
        g_err_r <= f_err_r;
      end else begin
        g_ma_r  <= gm1;
        g_mb_r  <= s_e.val;
        g_err_r <= f_err_r | s_e.err;
      end
      h_side_r[0] <= '{side: g_side_r, inner: g_inner_r, v: g_v_r, err: g_err_r};
      h_side_r[1] <= h_side_r[0];
    end
  end

  sgc_mul u_mul_fin (.clk, .en, .a(g_ma_r), .b(g_mb_r), .p(p_fin));

  // ---------------- final stage ----------------
  sres_t    s_q, s_o4;
  sgc_out_t fin_nxt;
  side_h_t  hs;

  always_comb begin
    hs                  = h_side_r[1];
    s_q                 = sat_prod(p_fin);
    fin_nxt.density_out = hs.side.rho;
    if (hs.side.cmd == CMD_P2C) begin
      s_o4               = sat_add(hs.inner, half_q(s_q.val));
      fin_nxt.second_out = hs.side.o2;
      fin_nxt.third_out  = hs.side.o3;
    end else begin
      s_o4               = sat_sub(s_q.val, hs.side.gp);
      fin_nxt.second_out = hs.inner;
      fin_nxt.third_out  = hs.v;
    end
    fin_nxt.fourth_out = s_o4.val;
    fin_nxt.error_flag = hs.err | s_q.err | s_o4.err;
    if (hs.side.cmd == CMD_C2P && hs.side.rho == '0) begin
      fin_nxt.second_out = '0;
      fin_nxt.third_out  = '0;
      fin_nxt.fourth_out = '0;
      fin_nxt.error_flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (en && v_r[NST-1]) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v_r[NST-1]) begin
      out_r <= fin_r;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  // ---------------- assertions ----------------
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v_r[NST-1]))
    else $error("result appeared without a transaction in the last stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline valid bits moved during a stall");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_valid_r && v_r[NST-1]))
    else $error("input blocked while pipeline has room");

endmodule

[tb/sv/tb.sv]
// Testbench for the stiffened-gas state converter: random and directed cells against a predictor.
`timescale 1ns / 1ps
module tb;
  import sgc_pkg::*;

  localparam int LATENCY = 64 / 2 + 12;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  sgc_stream_if #(.payload_t(sgc_in_t)) in_chan ();
  sgc_stream_if #(.payload_t(sgc_out_t)) out_chan ();

  stiffened_gas_state_conversion_top dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  logic [GAMMA_W-1:0] gamma_cfg;
  logic [PINF_W-1:0]  pinf_cfg;
  sgc_in_t  cell_queue[$];
  sgc_out_t state_queue[$];
  int       n_fail;
  int       in_gap;
  int       out_gap;
  bit       calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic q_t sat_wide(input qw_t w, inout logic err);
    qw_t hi;
    qw_t lo;
    hi = qw_t'(Q_MAX);
    lo = qw_t'(Q_MIN);
    if (w > hi) begin
      err = 1'b1;
      return Q_MAX;
    end
    if (w < lo) begin
      err = 1'b1;
      return Q_MIN;
    end
    return q_t'(w);
  endfunction

  function automatic q_t fx_mul(input q_t a, input q_t b, inout logic err);
    qw_t wa;
    qw_t wb;
    wa = qw_t'(a);
    wb = qw_t'(b);
    return sat_wide((wa * wb) >>> 32, err);
  endfunction

  function automatic q_t floor_div(input qw_t n, input q_t d, inout logic err);
    qw_t wd;
    qw_t quo;
    qw_t rem;
    if (d == 0) begin
      err = 1'b1;
      if (n == 0) return '0;
      return n < 0 ? Q_MIN : Q_MAX;
    end
    wd = qw_t'(d);
    quo = n / wd;
    rem = n - quo * wd;
    if (rem != 0 && ((n < 0) != (d < 0))) quo = quo - 1;
    return sat_wide(quo, err);
  endfunction

  function automatic q_t fx_add(input q_t a, input q_t b, inout logic err);
    qw_t wa;
    qw_t wb;
    wa = qw_t'(a);
    wb = qw_t'(b);
    return sat_wide(wa + wb, err);
  endfunction

  function automatic q_t fx_sub(input q_t a, input q_t b, inout logic err);
    qw_t wa;
    qw_t wb;
    wa = qw_t'(a);
    wb = qw_t'(b);
    return sat_wide(wa - wb, err);
  endfunction

  function automatic sgc_out_t convert_cell(input sgc_in_t c);
    sgc_out_t r;
    logic err;
    q_t g;
    q_t pinf;
    q_t gm1;
    q_t gp;
    q_t inner;
    q_t sq;
    q_t kin;
    q_t kx;
    q_t ky;
    q_t e;
    qw_t wa;
    qw_t wn;
    err = 1'b0;
    g = q_t'({28'b0, gamma_cfg});
    pinf = q_t'({1'b0, pinf_cfg});
    gm1 = g - Q_ONE;
    r.density_out = c.density_in;
    if (c.command == CMD_P2C) begin
      r.second_out = fx_mul(c.density_in, c.second_in, err);
      r.third_out = fx_mul(c.density_in, c.third_in, err);
      gp = fx_mul(g, pinf, err);
      wa = qw_t'(fx_add(c.fourth_in, gp, err));
      inner = floor_div(wa <<< 32, gm1, err);
      sq = fx_add(fx_mul(c.second_in, c.second_in, err),
                  fx_mul(c.third_in, c.third_in, err), err);
      kin = fx_mul(c.density_in, sq, err) >>> 1;
      r.fourth_out = fx_add(inner, kin, err);
    end else if (c.density_in == 0) begin
      r.second_out = '0;
      r.third_out = '0;
      r.fourth_out = '0;
      err = 1'b1;
    end else begin
      wa = qw_t'(c.second_in);
      r.second_out = floor_div(wa <<< 32, c.density_in, err);
      wn = wa * wa;
      kx = floor_div(wn, c.density_in, err);
      wa = qw_t'(c.third_in);
      r.third_out = floor_div(wa <<< 32, c.density_in, err);
      wn = wa * wa;
      ky = floor_div(wn, c.density_in, err);
      kin = fx_add(kx >>> 1, ky >>> 1, err);
      e = fx_sub(c.fourth_in, kin, err);
      r.fourth_out = fx_sub(fx_mul(gm1, e, err), fx_mul(g, pinf, err), err);
    end
    r.error_flag = err;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.payload <= '0;
      in_gap <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        state_queue.push_back(convert_cell(in_chan.payload));
      if (in_chan.valid && !in_chan.ready) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_chan.valid <= 1'b0;
      end else if (cell_queue.size() > 0) begin
        in_chan.payload <= cell_queue.pop_front();
        in_chan.valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sgc_out_t want;
    sgc_out_t got;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = out_chan.payload;
        if (state_queue.size() == 0) begin
          $error("unexpected transaction at output");
          n_fail++;
        end else begin
          want = state_queue.pop_front();
          if (got.density_out !== want.density_out) begin
            $error("density_out exp %h got %h", want.density_out, got.density_out);
            n_fail++;
          end
          if (got.second_out !== want.second_out) begin
            $error("second_out exp %h got %h", want.second_out, got.second_out);
            n_fail++;
          end
          if (got.third_out !== want.third_out) begin
            $error("third_out exp %h got %h", want.third_out, got.third_out);
            n_fail++;
          end
          if (got.fourth_out !== want.fourth_out) begin
            $error("fourth_out exp %h got %h", want.fourth_out, got.fourth_out);
            n_fail++;
          end
          if (got.error_flag !== want.error_flag) begin
            $error("error_flag exp %b got %b", want.error_flag, got.error_flag);
            n_fail++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_GAMMA) gamma_cfg = value[GAMMA_W-1:0];
    else pinf_cfg = value[PINF_W-1:0];
  endtask

  task automatic drain();
    while (cell_queue.size() > 0 || state_queue.size() > 0 || in_chan.valid)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic q_t rand_raw();
    return q_t'({$urandom, $urandom});
  endfunction

  function automatic q_t rand_q(input int lo, input int hi);
    q_t v;
    v = q_t'($urandom_range(0, hi - lo));
    v = (v + lo) <<< 32;
    return v + q_t'($urandom);
  endfunction

  function automatic sgc_in_t rand_cell();
    sgc_in_t c;
    int r;
    r = $urandom_range(0, 99);
    c.command = 1'($urandom_range(0, 1));
    if (r < 15) begin
      c.density_in = rand_raw();
      c.second_in = rand_raw();
      c.third_in = rand_raw();
      c.fourth_in = rand_raw();
    end else begin
      c.density_in = (r < 20) ? q_t'(0) : rand_q(0, 200);
      if (r >= 20 && r < 25) c.density_in = -c.density_in;
      c.second_in = rand_q(-300, 300);
      c.third_in = rand_q(-300, 300);
      c.fourth_in = rand_q(-1000, 100000);
    end
    return c;
  endfunction

  task automatic push_cell(input logic cmd, input q_t d, input q_t a, input q_t b,
                           input q_t e);
    sgc_in_t c;
    c.command = cmd;
    c.density_in = d;
    c.second_in = a;
    c.third_in = b;
    c.fourth_in = e;
    cell_queue.push_back(c);
  endtask

  initial begin
    logic [GAMMA_W-1:0] gammas[7];
    logic [DATA_W-1:0]  pinfs[7];
    n_fail = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gamma_cfg = GAMMA_RESET;
    pinf_cfg = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int cmd = 0; cmd < 2; cmd++) begin
      push_cell(1'(cmd), Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      push_cell(1'(cmd), Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      push_cell(1'(cmd), Q_MAX, Q_MIN, Q_MAX, Q_MIN);
      push_cell(1'(cmd), '0, '0, '0, '0);
      push_cell(1'(cmd), '0, Q_ONE, -Q_ONE, Q_ONE);
      push_cell(1'(cmd), -64'sd1, -64'sd1, -64'sd1, -64'sd1);
      push_cell(1'(cmd), 64'sd1, Q_MAX, Q_MIN, 64'sd1);
      push_cell(1'(cmd), -Q_ONE * 3, Q_ONE * 2, Q_ONE, -Q_ONE * 5);
      push_cell(1'(cmd), Q_ONE, Q_ONE * 3, -Q_ONE * 4, Q_ONE * 100);
      push_cell(1'(cmd), Q_ONE >>> 4, Q_ONE * 7, Q_ONE * 9, Q_ONE * 2);
    end
    drain();

    gammas = '{36'd4294967297, 36'd34359738368, 36'h1_0000_0000, 36'h0_8000_0000,
               36'hF_FFFF_FFFF, 36'd0, 36'd6012954214};
    pinfs = '{64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd3 << 32, 64'h0000_1234_5678_9ABC,
              64'd1, 64'h4000_0000_0000_0000, 64'd25 << 32};
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_GAMMA, DATA_W'(gammas[ph]));
      write_reg(REG_PINF, pinfs[ph]);
      for (int i = 0; i < 120; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(0, 2) == 0);
        cell_queue.push_back(rand_cell());
      end
      drain();
    end

    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
